FILE: rtl/core/cartridge_bank_mapper_scanline_irq_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bank mapper
// Shared property forms, clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds on that edge.
`define CBM_ASSERT_SAME(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) \
		(ante) |-> (cons)) else $error("mapper assertion failed");

// Next-cycle implication: whenever ante holds, cons holds on the next edge.
`define CBM_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) \
		(ante) |=> (cons)) else $error("mapper assertion failed");

`endif

FILE: rtl/core/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the bank mapper modules.
// ----------------------------------------------------------------------------
package cbm_pkg;

	typedef enum logic [1:0] {
		OP_CPU_WRITE   = 2'd0,
		OP_VIDEO_SEEN  = 2'd1,
		OP_CPU_XLATE   = 2'd2,
		OP_VIDEO_XLATE = 2'd3
	} cbm_op_t;

	// Mapper register select, coded as {addr[14], addr[13], addr[0]}
	typedef enum logic [2:0] {
		REG_BANK_SELECT = 3'b000,
		REG_BANK_DATA   = 3'b001,
		REG_MIRROR      = 3'b010,
		REG_WRAM        = 3'b011,
		REG_IRQ_LATCH   = 3'b100,
		REG_IRQ_RELOAD  = 3'b101,
		REG_IRQ_DISABLE = 3'b110,
		REG_IRQ_ENABLE  = 3'b111
	} cbm_reg_t;

	localparam logic [1:0] CFG_PRG_BANK_BITS = 2'd0;
	localparam logic [1:0] CFG_CHR_BANK_BITS = 2'd1;
	localparam logic [1:0] CFG_FOUR_SCREEN   = 2'd2;

	localparam logic [1:0] WRAM_NONE       = 2'd0;
	localparam logic [1:0] WRAM_READ_ONLY  = 2'd1;
	localparam logic [1:0] WRAM_READ_WRITE = 2'd2;

	localparam logic [7:0] BANK_SECOND_LAST = 8'hFE;
	localparam logic [7:0] BANK_LAST        = 8'hFF;

	typedef logic [7:0][7:0] bank_regs_t;

	localparam bank_regs_t BANK_RESET = {8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

	// Mode and size bits the translator needs
	typedef struct packed {
		logic       prg_swap;
		logic       chr_invert;
		logic [3:0] prg_bank_bits;
		logic [3:0] chr_bank_bits;
	} cbm_xlate_ctl_t;

	// Bank number mask for 2**bits banks, saturating at 8 bits
	function automatic logic [7:0] bank_mask(input logic [3:0] bits);
		logic [7:0] m;
		if (bits >= 4'd8) begin
			m = 8'hFF;
		end else begin
			m = ~(8'hFF << bits[2:0]);
		end
		return m;
	endfunction

endpackage

FILE: rtl/core/cartridge_bank_mapper_scanline_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_scanline_irq
// Bank-switching mapper with scanline IRQ counter: register writes, A12
// edge counting, and program / character ROM address translation.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------
//  s_*      | in        | s_tvalid / s_tready    | tdata: bus_address, write_data
//           |           |                        | tuser: opcode
//  m_*      | out       | m_tvalid / m_tready    | tdata: rom_offset, irq_line,
//           |           |                        |        mirror_horizontal, wram_access
//           |           |                        | tuser: offset_valid
//  cfg_*    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transaction per cycle sustained while m_tready stays high; a result passes
// through the input register, then the result register, before it is offered
// on m_*.
// Mapper state is updated as an item moves from the input register into the
// result register, so each result reflects the state after its own item.
// A stalled result register holds the input register; s_tready falls only
// when both stages are full and m_tready is low.
// Reset clears the mapper state to its power-on values and empties both stages.
// Configuration writes are always taken and apply on the next cycle.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_scanline_irq_assert.svh"

module cartridge_bank_mapper_scanline_irq (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] write_data
	input  logic [1:0]  s_tuser,   // [1:0] opcode

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [20:0] rom_offset, [21] irq_line,
	                               // [22] mirror_horizontal, [24:23] wram_access
	output logic        m_tuser,   // [0] offset_valid

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	import cbm_pkg::*;

	// Configuration registers
	logic [3:0] prg_bank_bits_q;
	logic [3:0] chr_bank_bits_q;
	logic       four_screen_q;

	// Input stage
	logic        valid_s1;
	cbm_op_t     opcode_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	// Mapper state
	bank_regs_t bank_regs_q,  bank_regs_d;
	logic [2:0] reg_index_q,  reg_index_d;
	logic       prg_swap_q,   prg_swap_d;
	logic       chr_invert_q, chr_invert_d;
	logic       mirror_q,     mirror_d;
	logic       wram_on_q,    wram_on_d;
	logic       wram_prot_q,  wram_prot_d;
	logic [7:0] irq_latch_q,  irq_latch_d;
	logic [7:0] irq_count_q,  irq_count_d;
	logic       reload_q,     reload_d;
	logic       irq_on_q,     irq_on_d;
	logic       irq_asserted_q, irq_asserted_d;
	logic       a12_low_q,    a12_low_d;

	// Result stage
	logic        out_valid_q;
	logic [20:0] rom_offset_q;
	logic        offset_valid_q;
	logic        irq_line_q;
	logic        mirror_h_q;
	logic [1:0]  wram_access_q;

	logic           adv;
	logic           in_take;
	cbm_reg_t       reg_sel;
	cbm_xlate_ctl_t xctl;
	logic [20:0]    xl_offset;
	logic           xl_valid;

	// Advance when the result register is empty or being drained
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_take  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// ---- configuration ----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_bits_q <= 4'd5;
			chr_bank_bits_q <= 4'd8;
			four_screen_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PRG_BANK_BITS: prg_bank_bits_q <= cfg_data;
				CFG_CHR_BANK_BITS: chr_bank_bits_q <= cfg_data;
				CFG_FOUR_SCREEN:   four_screen_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---- input stage ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload loads on every accepted transaction; no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1 <= cbm_op_t'(s_tuser);
			addr_s1   <= s_tdata[15:0];
			data_s1   <= s_tdata[23:16];
		end
	end

	// ---- mapper state update ----------------------------------------------
	// Register select mirrors the 0xE001 decode of the cpu address
	assign reg_sel = cbm_reg_t'({addr_s1[14], addr_s1[13], addr_s1[0]});

	always_comb begin
		logic [7:0] cnt_next;
		bank_regs_d    = bank_regs_q;
		reg_index_d    = reg_index_q;
		prg_swap_d     = prg_swap_q;
		chr_invert_d   = chr_invert_q;
		mirror_d       = mirror_q;
		wram_on_d      = wram_on_q;
		wram_prot_d    = wram_prot_q;
		irq_latch_d    = irq_latch_q;
		irq_count_d    = irq_count_q;
		reload_d       = reload_q;
		irq_on_d       = irq_on_q;
		irq_asserted_d = irq_asserted_q;
		a12_low_d      = a12_low_q;
		cnt_next       = (irq_count_q == 8'd0 || reload_q) ? irq_latch_q
			: irq_count_q - 8'd1;

		if (opcode_s1 == OP_CPU_WRITE && addr_s1[15]) begin
			unique case (reg_sel)
				REG_BANK_SELECT: begin
					reg_index_d  = data_s1[2:0];
					chr_invert_d = data_s1[7];
					prg_swap_d   = data_s1[6];
				end
				REG_BANK_DATA: begin
					// Two-KB character banks drop bit 0
					if (reg_index_q <= 3'd1) begin
						bank_regs_d[reg_index_q] = {data_s1[7:1], 1'b0};
					end else begin
						bank_regs_d[reg_index_q] = data_s1;
					end
				end
				REG_MIRROR: mirror_d = data_s1[0];
				REG_WRAM: begin
					wram_on_d   = data_s1[7];
					wram_prot_d = data_s1[6];
				end
				REG_IRQ_LATCH: irq_latch_d = data_s1;
				REG_IRQ_RELOAD: begin
					irq_count_d = 8'd0;
					reload_d    = 1'b1;
				end
				REG_IRQ_DISABLE: begin
					irq_on_d       = 1'b0;
					irq_asserted_d = 1'b0;
				end
				REG_IRQ_ENABLE: irq_on_d = 1'b1;
				default: ;
			endcase
		end else if (opcode_s1 == OP_VIDEO_SEEN) begin
			// Clock the counter on a low-to-high move of A12
			if (!addr_s1[12]) begin
				a12_low_d = 1'b1;
			end else if (a12_low_q) begin
				a12_low_d   = 1'b0;
				irq_count_d = cnt_next;
				reload_d    = 1'b0;
				if (cnt_next == 8'd0 && irq_on_q) begin
					irq_asserted_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_regs_q    <= BANK_RESET;
			reg_index_q    <= '0;
			prg_swap_q     <= 1'b0;
			chr_invert_q   <= 1'b0;
			mirror_q       <= 1'b0;
			wram_on_q      <= 1'b0;
			wram_prot_q    <= 1'b0;
			irq_latch_q    <= '0;
			irq_count_q    <= '0;
			reload_q       <= 1'b0;
			irq_on_q       <= 1'b0;
			irq_asserted_q <= 1'b0;
			a12_low_q      <= 1'b0;
		end else if (adv) begin
			bank_regs_q    <= bank_regs_d;
			reg_index_q    <= reg_index_d;
			prg_swap_q     <= prg_swap_d;
			chr_invert_q   <= chr_invert_d;
			mirror_q       <= mirror_d;
			wram_on_q      <= wram_on_d;
			wram_prot_q    <= wram_prot_d;
			irq_latch_q    <= irq_latch_d;
			irq_count_q    <= irq_count_d;
			reload_q       <= reload_d;
			irq_on_q       <= irq_on_d;
			irq_asserted_q <= irq_asserted_d;
			a12_low_q      <= a12_low_d;
		end
	end

	// ---- translation ------------------------------------------------------
	// Translate items do not change state, so the current registers serve
	assign xctl.prg_swap      = prg_swap_q;
	assign xctl.chr_invert    = chr_invert_q;
	assign xctl.prg_bank_bits = prg_bank_bits_q;
	assign xctl.chr_bank_bits = chr_bank_bits_q;

	cbm_translate u_translate (
		.opcode       (opcode_s1),
		.bus_address  (addr_s1),
		.bank_regs    (bank_regs_q),
		.ctl          (xctl),
		.rom_offset   (xl_offset),
		.offset_valid (xl_valid)
	);

	// ---- result stage -----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Status fields report the state after this item
	always_ff @(posedge clk) begin
		if (adv) begin
			rom_offset_q   <= xl_offset;
			offset_valid_q <= xl_valid;
			irq_line_q     <= irq_asserted_d;
			mirror_h_q     <= four_screen_q ? 1'b0 : mirror_d;
			wram_access_q  <= wram_on_d ? (wram_prot_d ? WRAM_READ_ONLY : WRAM_READ_WRITE)
				: WRAM_NONE;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, wram_access_q, mirror_h_q, irq_line_q, rom_offset_q};
	assign m_tuser  = offset_valid_q;

	// ---- assertions -------------------------------------------------------
	`CBM_ASSERT_NEXT(a_irq_only_from_video, clk, arst_n,
		adv && opcode_s1 != OP_VIDEO_SEEN, !$rose(irq_asserted_q))
	`CBM_ASSERT_NEXT(a_s1_holds_on_stall, clk, arst_n, valid_s1 && !adv, valid_s1)
	`CBM_ASSERT_NEXT(a_adv_fills_result, clk, arst_n, adv, out_valid_q)
	`CBM_ASSERT_SAME(a_low_banks_even, clk, arst_n, 1'b1,
		!bank_regs_q[0][0] && !bank_regs_q[1][0])

endmodule

FILE: rtl/core/cbm_translate.sv
// ----------------------------------------------------------------------------
// cbm_translate
// Program and character ROM address translation from the bank registers.
// ----------------------------------------------------------------------------
module cbm_translate (
	input  cbm_pkg::cbm_op_t       opcode,
	input  logic [15:0]            bus_address,
	input  cbm_pkg::bank_regs_t    bank_regs,
	input  cbm_pkg::cbm_xlate_ctl_t ctl,
	output logic [20:0]            rom_offset,
	output logic                   offset_valid
);
	import cbm_pkg::*;

	logic [1:0] prg_slot;
	logic [2:0] chr_eff;
	logic [2:0] rd_idx;
	logic       use_fixed;
	logic [7:0] fixed_bank;
	logic [7:0] reg_bank;
	logic [7:0] prg_bank;
	logic [7:0] chr_bank;

	assign prg_slot = bus_address[14:13];
	assign chr_eff  = bus_address[12:10] ^ {ctl.chr_invert, 2'b00};

	// One bank register read per item: pick the index first, then mux once
	always_comb begin
		rd_idx     = 3'd6;
		use_fixed  = 1'b0;
		fixed_bank = BANK_LAST;
		if (opcode == OP_CPU_XLATE) begin
			case (prg_slot)
				2'd0: begin
					use_fixed  = ctl.prg_swap;
					fixed_bank = BANK_SECOND_LAST;
					rd_idx     = 3'd6;
				end
				2'd1: begin
					rd_idx = 3'd7;
				end
				2'd2: begin
					use_fixed  = !ctl.prg_swap;
					fixed_bank = BANK_SECOND_LAST;
					rd_idx     = 3'd6;
				end
				default: begin
					use_fixed  = 1'b1;
					fixed_bank = BANK_LAST;
				end
			endcase
		end else if (!chr_eff[2]) begin
			rd_idx = {2'b00, chr_eff[1]};
		end else begin
			rd_idx = chr_eff - 3'd2;
		end
	end

	assign reg_bank = bank_regs[rd_idx];
	assign prg_bank = (use_fixed ? fixed_bank : reg_bank) & bank_mask(ctl.prg_bank_bits);
	assign chr_bank = (chr_eff[2] ? reg_bank : {reg_bank[7:1], chr_eff[0]})
		& bank_mask(ctl.chr_bank_bits);

	always_comb begin
		rom_offset   = '0;
		offset_valid = 1'b0;
		case (opcode)
			OP_CPU_XLATE: begin
				if (bus_address[15]) begin
					rom_offset   = {prg_bank, bus_address[12:0]};
					offset_valid = 1'b1;
				end
			end
			OP_VIDEO_XLATE: begin
				if (!bus_address[13]) begin
					rom_offset   = {3'b000, chr_bank, bus_address[9:0]};
					offset_valid = 1'b1;
				end
			end
			default: begin
				rom_offset   = '0;
				offset_valid = 1'b0;
			end
		endcase
	end

endmodule
